[sv/cdsw_pkg.sv]
// Shared types and constants for the calendar date stepper with weekday.
package cdsw_pkg;

   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int WDAY_W  = 3;
   localparam int KIND_W  = 3;
   localparam int STAT_W  = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;

   localparam logic [YEAR_W-1:0]  RESET_YEAR  = 14'd2000;
   localparam logic [MONTH_W-1:0] RESET_MONTH = 4'd1;
   localparam logic [DAY_W-1:0]   RESET_DAY   = 5'd1;
   localparam logic               RESET_LEAP  = 1'b1;
   localparam logic [DAY_W-1:0]   RESET_MDAYS = 5'd31;

   localparam logic [KIND_W-1:0] REQ_NEXT_MONTH = 3'd0;
   localparam logic [KIND_W-1:0] REQ_PREV_MONTH = 3'd1;
   localparam logic [KIND_W-1:0] REQ_NEXT_YEAR  = 3'd2;
   localparam logic [KIND_W-1:0] REQ_PREV_YEAR  = 3'd3;
   localparam logic [KIND_W-1:0] REQ_NEXT_DAY   = 3'd4;
   localparam logic [KIND_W-1:0] REQ_PREV_DAY   = 3'd5;
   localparam logic [KIND_W-1:0] REQ_SET        = 3'd6;
   localparam logic [KIND_W-1:0] REQ_TODAY      = 3'd7;

   localparam logic [STAT_W-1:0] STAT_OK          = 2'd0;
   localparam logic [STAT_W-1:0] STAT_BAD_SET     = 2'd1;
   localparam logic [STAT_W-1:0] STAT_DAY_OVERRUN = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_TODAY_YEAR  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TODAY_MONTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TODAY_DAY   = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
   } request_type;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
   } today_type;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic               leap;
      logic [DAY_W-1:0]   mdays;
      logic [STAT_W-1:0]  status;
   } date_type;

   typedef struct packed {
      date_type          date;
      logic [WDAY_W-1:0] weekday;
      logic [WDAY_W-1:0] first_weekday;
   } rsp_type;

   typedef struct packed {
      logic load_sum;
      logic load_rsp;
   } ctrl_type;

endpackage

[sv/cdsw_date.sv]
// Date stage: holds the current date and applies one request to it per cycle while enabled.
module cdsw_date
   import cdsw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        enable,
   input  request_type req,
   input  today_type   today,
   output date_type    date
);

   logic [YEAR_W-1:0]  year_ff, year_in;
   logic [MONTH_W-1:0] month_ff, month_in;
   logic [DAY_W-1:0]   day_ff, day_in;
   logic               leap_ff, leap_in;
   logic [DAY_W-1:0]   mdays_ff, mdays_in;
   logic [STAT_W-1:0]  status_ff, status_in;

   logic [YEAR_W-1:0]  cand_year, today_year;
   logic [MONTH_W-1:0] cand_month, today_month;
   logic [DAY_W-1:0]   cand_day, today_day, cand_len, today_len;
   logic               cand_leap, today_leap, to_today, bad_set;

   function automatic logic leap_of(input logic [YEAR_W-1:0] y);
      logic [28:0]       prod;
      logic [9:0]        q;
      logic [YEAR_W-1:0] back;
      logic              div25;
      prod  = 29'(y) * 29'd20972;
      q     = prod[28:19];
      back  = 14'(q) * 14'd25;
      div25 = (back == y);
      return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic leap, input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] n;
      case (m) inside
         4'd2:                   n = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
         default:                n = 5'd31;
      endcase
      return n;
   endfunction

   always_comb begin
      cand_year  = year_ff;
      cand_month = month_ff;
      cand_day   = day_ff;
      to_today   = 1'b0;
      bad_set    = 1'b0;
      unique case (req.kind)
         REQ_NEXT_MONTH: begin
            if (month_ff < 4'd12) begin
               cand_month = month_ff + 4'd1;
            end else if (year_ff < YEAR_MAX) begin
               cand_year  = year_ff + 14'd1;
               cand_month = 4'd1;
            end
         end
         REQ_PREV_MONTH: begin
            if (month_ff > 4'd1) begin
               cand_month = month_ff - 4'd1;
            end else if (year_ff > 14'd1) begin
               cand_year  = year_ff - 14'd1;
               cand_month = 4'd12;
            end
         end
         REQ_NEXT_YEAR: begin
            if (year_ff < YEAR_MAX) begin
               cand_year = year_ff + 14'd1;
            end
         end
         REQ_PREV_YEAR: begin
            if (year_ff > 14'd1) begin
               cand_year = year_ff - 14'd1;
            end
         end
         REQ_NEXT_DAY: begin
            if (day_ff != mdays_ff) begin
               cand_day = day_ff + 5'd1;
            end else if (month_ff == 4'd12) begin
               if (year_ff < YEAR_MAX) begin
                  cand_year  = year_ff + 14'd1;
                  cand_month = 4'd1;
                  cand_day   = 5'd1;
               end
            end else begin
               cand_month = month_ff + 4'd1;
               cand_day   = 5'd1;
            end
         end
         REQ_PREV_DAY: begin
            if (day_ff != 5'd1) begin
               cand_day = day_ff - 5'd1;
            end else if (month_ff == 4'd1) begin
               if (year_ff > 14'd1) begin
                  cand_year  = year_ff - 14'd1;
                  cand_month = 4'd12;
                  cand_day   = 5'd31;
               end
            end else begin
               cand_month = month_ff - 4'd1;
               cand_day   = month_len(leap_ff, month_ff - 4'd1);
            end
         end
         REQ_SET: begin
            if (req.year == 14'd0 || req.month == 4'd0 || req.month > 4'd12
                || req.day == 5'd0) begin
               to_today = 1'b1;
               bad_set  = 1'b1;
            end else begin
               cand_year  = (req.year > YEAR_MAX) ? YEAR_MAX : req.year;
               cand_month = req.month;
               cand_day   = req.day;
            end
         end
         REQ_TODAY: begin
            to_today = 1'b1;
         end
         default: begin
            to_today = 1'b1;
         end
      endcase
   end

   assign cand_leap = leap_of(cand_year);
   assign cand_len  = month_len(cand_leap, cand_month);

   // clamp today into a valid date
   assign today_year  = (today.year == 14'd0) ? 14'd1 :
                        (today.year > YEAR_MAX) ? YEAR_MAX : today.year;
   assign today_month = (today.month == 4'd0) ? 4'd1 :
                        (today.month > 4'd12) ? 4'd12 : today.month;
   assign today_leap  = leap_of(today_year);
   assign today_len   = month_len(today_leap, today_month);
   assign today_day   = (today.day == 5'd0) ? 5'd1 :
                        (today.day > today_len) ? today_len : today.day;

   always_comb begin
      if (to_today || cand_day > cand_len) begin
         year_in  = today_year;
         month_in = today_month;
         day_in   = today_day;
         leap_in  = today_leap;
         mdays_in = today_len;
         if (bad_set) begin
            status_in = STAT_BAD_SET;
         end else if (to_today) begin
            status_in = STAT_OK;
         end else begin
            status_in = STAT_DAY_OVERRUN;
         end
      end else begin
         year_in   = cand_year;
         month_in  = cand_month;
         day_in    = cand_day;
         leap_in   = cand_leap;
         mdays_in  = cand_len;
         status_in = STAT_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         year_ff   <= RESET_YEAR;
         month_ff  <= RESET_MONTH;
         day_ff    <= RESET_DAY;
         leap_ff   <= RESET_LEAP;
         mdays_ff  <= RESET_MDAYS;
         status_ff <= STAT_OK;
      end else if (enable) begin
         year_ff   <= year_in;
         month_ff  <= month_in;
         day_ff    <= day_in;
         leap_ff   <= leap_in;
         mdays_ff  <= mdays_in;
         status_ff <= status_in;
      end
   end

   assign date.year   = year_ff;
   assign date.month  = month_ff;
   assign date.day    = day_ff;
   assign date.leap   = leap_ff;
   assign date.mdays  = mdays_ff;
   assign date.status = status_ff;

endmodule

[sv/cdsw_wday.sv]
// Weekday stages: day-count sums, then reduction modulo seven into the result register.
module cdsw_wday
   import cdsw_pkg::*;
(
   input  logic     clock,
   input  ctrl_type ctrl,
   input  date_type date,
   output rsp_type  rsp
);

   logic [YEAR_W-1:0] p;
   logic [29:0]       prod100;
   logic [7:0]        q100;
   logic [14:0]       base;
   logic [14:0]       sum_day_in, sum_first_in;

   logic [14:0] sum_day_ff, sum_first_ff;
   date_type    hold_ff;
   rsp_type     rsp_ff, rsp_in;

   function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
      logic [8:0] n;
      case (m)
         4'd2:    n = 9'd31;
         4'd3:    n = 9'd59;
         4'd4:    n = 9'd90;
         4'd5:    n = 9'd120;
         4'd6:    n = 9'd151;
         4'd7:    n = 9'd181;
         4'd8:    n = 9'd212;
         4'd9:    n = 9'd243;
         4'd10:   n = 9'd273;
         4'd11:   n = 9'd304;
         4'd12:   n = 9'd334;
         default: n = 9'd0;
      endcase
      return n;
   endfunction

   function automatic logic [WDAY_W-1:0] mod7(input logic [14:0] x);
      logic [30:0] prod;
      logic [12:0] q;
      prod = 31'(x) * 31'd37450;
      q    = prod[30:18];
      return 3'(x - 15'(q) * 15'd7);
   endfunction

   // day count since 0001-01-01 less the century correction
   assign p       = date.year - 14'd1;
   assign prod100 = 30'(p) * 30'd41944;
   assign q100    = prod100[29:22];
   assign base    = 15'(p) + 15'(p[YEAR_W-1:2]) + 15'(q100[7:2]) - 15'(q100)
                    + 15'(days_before(date.month))
                    + 15'(date.leap && (date.month > 4'd2));
   assign sum_day_in   = base + 15'(date.day);
   assign sum_first_in = base + 15'd1;

   always_ff @(posedge clock) begin
      if (ctrl.load_sum) begin
         sum_day_ff   <= sum_day_in;
         sum_first_ff <= sum_first_in;
         hold_ff      <= date;
      end
   end

   always_comb begin
      rsp_in.date          = hold_ff;
      rsp_in.weekday       = mod7(sum_day_ff);
      rsp_in.first_weekday = mod7(sum_first_ff);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

[sv/calendar_date_stepper_weekday.sv]
// Top level of the calendar date stepper with weekday output.
//
// Requests enter on req_* (valid/stall); each one steps, sets or resets the held
// date and yields exactly one response on rsp_* (valid/stall) carrying the date,
// its weekday, the weekday of the 1st, the month length, the leap flag and a status.
// The csr_* port writes the today registers (index 0 year, 1 month, 2 day); it is
// always ready, and writes leave the held date alone.
// Throughput: one request per cycle while req_stall is low; the held date is
// updated in a single registered step, and the weekday sums and the
// modulo-seven reduction follow in two further registered stages.
// Each stage moves on when the stage after it is empty or moving, so a request
// is still taken while an earlier response waits to be collected.
// Reset: the held date returns to 2000-01-01, today to 2000-01-01, and all
// stages empty; no response is pending.
// Stall: while rsp_stall is high the response holds; once every stage is full,
// req_stall rises until the response is taken.
module calendar_date_stepper_weekday
   import cdsw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [KIND_W-1:0]    req_type,
   input  logic [YEAR_W-1:0]    req_set_year,
   input  logic [MONTH_W-1:0]   req_set_month,
   input  logic [DAY_W-1:0]     req_set_day,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [YEAR_W-1:0]    rsp_shown_year,
   output logic [MONTH_W-1:0]   rsp_shown_month,
   output logic [DAY_W-1:0]     rsp_shown_day,
   output logic [WDAY_W-1:0]    rsp_weekday,
   output logic [WDAY_W-1:0]    rsp_first_weekday,
   output logic [DAY_W-1:0]     rsp_month_days,
   output logic                 rsp_leap_year,
   output logic [STAT_W-1:0]    rsp_status,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [YEAR_W-1:0]    csr_data
);

   logic        in_vld_ff, date_vld_ff, sum_vld_ff, rsp_vld_ff;
   logic        load_in, load_date, load_sum, load_rsp;
   request_type req_ff;
   today_type   today_ff;
   date_type    date;
   rsp_type     rsp;
   ctrl_type    ctrl;

   assign load_rsp  = !rsp_vld_ff || !rsp_stall;
   assign load_sum  = !sum_vld_ff || load_rsp;
   assign load_date = !date_vld_ff || load_sum;
   assign load_in   = !in_vld_ff || load_date;

   assign req_stall = !load_in;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         date_vld_ff <= 1'b0;
         sum_vld_ff  <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         if (load_in) begin
            in_vld_ff <= req_valid;
         end
         if (load_date) begin
            date_vld_ff <= in_vld_ff;
         end
         if (load_sum) begin
            sum_vld_ff <= date_vld_ff;
         end
         if (load_rsp) begin
            rsp_vld_ff <= sum_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_in && req_valid) begin
         req_ff.kind  <= req_type;
         req_ff.year  <= req_set_year;
         req_ff.month <= req_set_month;
         req_ff.day   <= req_set_day;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         today_ff.year  <= RESET_YEAR;
         today_ff.month <= RESET_MONTH;
         today_ff.day   <= RESET_DAY;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TODAY_YEAR:  today_ff.year  <= csr_data;
            CSR_TODAY_MONTH: today_ff.month <= csr_data[MONTH_W-1:0];
            CSR_TODAY_DAY:   today_ff.day   <= csr_data[DAY_W-1:0];
            default: begin
            end
         endcase
      end
   end

   cdsw_date u_date (
      .clock  (clock),
      .reset  (reset),
      .enable (in_vld_ff && load_date),
      .req    (req_ff),
      .today  (today_ff),
      .date   (date)
   );

   assign ctrl.load_sum = load_sum;
   assign ctrl.load_rsp = load_rsp;

   cdsw_wday u_wday (
      .clock (clock),
      .ctrl  (ctrl),
      .date  (date),
      .rsp   (rsp)
   );

   assign rsp_valid         = rsp_vld_ff;
   assign rsp_shown_year    = rsp.date.year;
   assign rsp_shown_month   = rsp.date.month;
   assign rsp_shown_day     = rsp.date.day;
   assign rsp_weekday       = rsp.weekday;
   assign rsp_first_weekday = rsp.first_weekday;
   assign rsp_month_days    = rsp.date.mdays;
   assign rsp_leap_year     = rsp.date.leap;
   assign rsp_status        = rsp.date.status;

endmodule

[sv/cdsw_check.sv]
// Port-level checker for the date stepper, bound to the top level.
module cdsw_check
   import cdsw_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic [KIND_W-1:0]    req_type,
   input logic [YEAR_W-1:0]    req_set_year,
   input logic [MONTH_W-1:0]   req_set_month,
   input logic [DAY_W-1:0]     req_set_day,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [YEAR_W-1:0]    rsp_shown_year,
   input logic [MONTH_W-1:0]   rsp_shown_month,
   input logic [DAY_W-1:0]     rsp_shown_day,
   input logic [WDAY_W-1:0]    rsp_weekday,
   input logic [WDAY_W-1:0]    rsp_first_weekday,
   input logic [DAY_W-1:0]     rsp_month_days,
   input logic                 rsp_leap_year,
   input logic [STAT_W-1:0]    rsp_status,
   input logic                 csr_valid,
   input logic                 csr_ready,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [YEAR_W-1:0]    csr_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_shown_year)
         && $stable(rsp_shown_month) && $stable(rsp_shown_day)
         && $stable(rsp_weekday) && $stable(rsp_status))
      else $error("response changed while stalled");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response pending straight after reset");

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_shown_year >= 14'd1 && rsp_shown_year <= YEAR_MAX
         && rsp_shown_month >= 4'd1 && rsp_shown_month <= 4'd12
         && rsp_shown_day >= 5'd1 && rsp_shown_day <= rsp_month_days
         && rsp_status != 2'd3)
      else $error("response date out of range");

   a_weekday_link: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_shown_day == 5'd1 |-> rsp_weekday == rsp_first_weekday
         && rsp_weekday <= 3'd6)
      else $error("weekday of the first disagrees with the date");

   a_february: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_shown_month == 4'd2 |->
         rsp_month_days == (rsp_leap_year ? 5'd29 : 5'd28))
      else $error("february length disagrees with leap flag");

endmodule

bind calendar_date_stepper_weekday cdsw_check u_check (.*);
